// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define CLSB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset
`define CLSB_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/clsb_pkg.sv =====
`timescale 1ns / 1ps
package clsb_pkg;

   localparam int COLS_DEF    = 16;
   localparam int ROWS_DEF    = 2;
   localparam int ROW_STRIDE  = 64;
   localparam int STORE_DEPTH = 128;
   localparam int STORE_AW    = 7;
   localparam int MAX_RESULTS = 64;
   localparam int RES_AW      = 6;
   localparam int RES_CNT_W   = 7;

   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam logic [7:0] CR_CHAR      = 8'd13;
   localparam logic [7:0] LF_CHAR      = 8'd10;
   localparam logic [7:0] SET_ADDR_CMD = 8'h80;

   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_CURSOR  = 2'd1,
      MODE_CLEAR   = 2'd2,
      MODE_REFRESH = 2'd3
   } mode_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_wr_type;

endpackage

// ===== design/clsb_ifs.sv =====
`timescale 1ns / 1ps
interface clsb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] char_code;
   logic [7:0] column;
   logic [7:0] row_index;
   logic       lcd_busy;

   modport source (output valid, mode, char_code, column, row_index, lcd_busy, input ready);
   modport sink   (input valid, mode, char_code, column, row_index, lcd_busy, output ready);
endinterface

interface clsb_rsp_if;
   logic       valid;
   logic       ready;
   logic       op_valid;
   logic       is_data;
   logic [7:0] lcd_byte;
   logic       refresh_pending;
   logic [7:0] cursor_position;
   logic       last;

   modport source (output valid, op_valid, is_data, lcd_byte, refresh_pending,
                   cursor_position, last, input ready);
   modport sink   (input valid, op_valid, is_data, lcd_byte, refresh_pending,
                   cursor_position, last, output ready);
endinterface

// ===== design/clsb_ram.sv =====
`timescale 1ns / 1ps
module clsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/clsb_store.sv =====
`timescale 1ns / 1ps
module clsb_store import clsb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  store_wr_type        wr,
   input  logic [STORE_AW-1:0] rd_addr,
   output logic [7:0]          rd_data
);

   logic [STORE_DEPTH-1:0] vld_ff;
   logic                   rd_vld_ff;
   logic [7:0]             ram_q;

   clsb_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // track written cells; unwritten cells read as space
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? ram_q : SPACE_CHAR;

endmodule

// ===== design/char_lcd_shadow_buffer_refresh_unit.sv =====
`timescale 1ns / 1ps
// Character display front end with a text store and a shadow of the display.
// req_chan carries one command beat: write character, set cursor, clear, or
// refresh step. rsp_chan returns one or more display beats per command; the
// final beat has last set, and a command with no display work returns one
// beat with op_valid low. csr_wr_en/csr_wr_data set the defer_updates bit;
// the user must write it only while the block is idle; the block does not enforce this.
// One command is processed at a time: req_chan.ready is high only when the
// sequencer is idle. A plain character, and each cell that a newline or
// immediate clear touches, takes a store read, a compare and an optional
// data step; a deferred clear blanks one cell per cycle, set cursor reduces
// the column by repeated subtraction, and a refresh step reads and compares
// one cell per pass, all through the single store read port and compare
// unit. Result beats are queued in a 64-entry buffer, drained afterwards.
// A stalled receiver simply holds the drain; no beat is lost.
// Reset clears the cell valid bits at once, so both stores read as spaces
// with no clearing pass; cursor, display and refresh addresses return to 0.
module char_lcd_shadow_buffer_refresh_unit import clsb_pkg::*; #(
   parameter int COLS = COLS_DEF,
   parameter int ROWS = ROWS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   clsb_req_if.sink      req_chan,
   clsb_rsp_if.source    rsp_chan,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data
);

`include "assert_macros.svh"

   localparam int          CELLS     = ROWS * COLS;
   localparam int          CNT_W     = $clog2(CELLS);
   localparam int          ROWS_LAST = ROWS - 1;
   localparam logic [7:0]  SPAN_MASK = 8'(ROWS * ROW_STRIDE - 1);
   localparam logic [7:0]  STRIDE8   = 8'(ROW_STRIDE);
   localparam logic [7:0]  ROW_MASK  = 8'(256 - ROW_STRIDE);
   localparam logic [7:0]  COLS8     = 8'(COLS);

   typedef enum logic [3:0] {
      S_IDLE, S_MOD, S_FILL, S_PUT_RD, S_PUT_CMP, S_PUT_DATA, S_DCLR,
      S_REF_RD, S_REF_CMP, S_FINISH, S_DRAIN_RD, S_DRAIN_LD, S_WAIT_OUT
   } state_type;

   state_type            state_ff;
   logic                 defer_ff;
   logic [7:0]           cursor_ff;
   logic [7:0]           disp_ff;
   logic [STORE_AW-1:0]  ref_ff;
   logic                 retdef_ff;
   logic [7:0]           put_ch_ff;
   logic                 row_bit_ff;
   logic                 busy_ff;
   logic [7:0]           mod_ff;
   logic                 fill_ff;
   logic                 lf_ff;
   logic [STORE_AW-1:0]  scan_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [RES_CNT_W-1:0] res_cnt_ff;
   logic [RES_AW-1:0]    rd_idx_ff;
   logic                 pending_ff;
   logic                 out_vld_ff;
   logic                 out_op_ff;
   logic                 out_data_ff;
   logic [7:0]           out_byte_ff;
   logic                 out_last_ff;

   store_wr_type         text_wr;
   store_wr_type         shown_wr;
   logic [STORE_AW-1:0]  shown_rd_addr;
   logic [7:0]           text_q;
   logic [7:0]           shown_q;
   logic                 res_wr_en;
   logic [8:0]           res_wr_data;
   logic [8:0]           res_q;

   logic                 put_diff;
   logic                 need_addr;
   logic                 room1;
   logic                 room2;
   logic                 ref_diff;
   logic                 ref_hit;
   logic [7:0]           cmd_put;
   logic [7:0]           cmd_ref;
   logic [7:0]           wc_cursor;
   logic                 req_fire;

   // start of the next row, wrapped over the address span
   function automatic logic [7:0] next_row(input logic [7:0] a);
      return ((a & ROW_MASK) + STRIDE8) & SPAN_MASK;
   endfunction

   // step the refresh address, skipping the gap past the last column
   function automatic logic [STORE_AW-1:0] adv_ref(input logic [STORE_AW-1:0] a);
      logic [7:0] b;
      b = {1'b0, a + 7'd1};
      if ({2'b0, b[5:0]} >= COLS8) begin
         b = next_row(b);
      end
      return b[STORE_AW-1:0];
   endfunction

   clsb_store u_text (
      .clock   (clock),
      .reset   (reset),
      .wr      (text_wr),
      .rd_addr (ref_ff),
      .rd_data (text_q)
   );

   clsb_store u_shown (
      .clock   (clock),
      .reset   (reset),
      .wr      (shown_wr),
      .rd_addr (shown_rd_addr),
      .rd_data (shown_q)
   );

   clsb_ram #(.WIDTH(9), .DEPTH(MAX_RESULTS)) u_res (
      .clock   (clock),
      .wr_en   (res_wr_en),
      .wr_addr (res_cnt_ff[RES_AW-1:0]),
      .wr_data (res_wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (res_q)
   );

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign put_diff  = put_ch_ff != shown_q;
   assign need_addr = disp_ff != cursor_ff;
   assign room1     = res_cnt_ff <= RES_CNT_W'(MAX_RESULTS - 1);
   assign room2     = res_cnt_ff <= RES_CNT_W'(MAX_RESULTS - 2);
   assign ref_diff  = text_q != shown_q;
   assign ref_hit   = disp_ff == {1'b0, ref_ff};
   assign cmd_put   = SET_ADDR_CMD | (cursor_ff & SPAN_MASK);
   assign cmd_ref   = SET_ADDR_CMD | {1'b0, ref_ff};

   // cursor for a printable character: pending return, then column wrap
   always_comb begin
      wc_cursor = retdef_ff ? (cursor_ff & ROW_MASK) : cursor_ff;
      if ({2'b0, wc_cursor[5:0]} >= COLS8) begin
         wc_cursor = next_row(wc_cursor);
      end
   end

   // drive store and result buffer ports from the sequencer state
   always_comb begin
      text_wr       = '0;
      shown_wr      = '0;
      shown_rd_addr = ref_ff;
      res_wr_en     = 1'b0;
      res_wr_data   = '0;
      case (state_ff)
         S_PUT_RD: begin
            text_wr       = '{en: 1'b1, addr: cursor_ff[STORE_AW-1:0], data: put_ch_ff};
            shown_rd_addr = cursor_ff[STORE_AW-1:0];
         end
         S_PUT_CMP: begin
            if (!defer_ff && put_diff && need_addr && room2) begin
               res_wr_en   = 1'b1;
               res_wr_data = {1'b0, cmd_put};
            end
         end
         S_PUT_DATA: begin
            res_wr_en   = 1'b1;
            res_wr_data = {1'b1, put_ch_ff};
            shown_wr    = '{en: 1'b1, addr: cursor_ff[STORE_AW-1:0], data: put_ch_ff};
         end
         S_DCLR: begin
            text_wr = '{en: 1'b1, addr: scan_ff, data: SPACE_CHAR};
         end
         S_REF_CMP: begin
            if (ref_diff && !busy_ff) begin
               res_wr_en = 1'b1;
               if (ref_hit) begin
                  res_wr_data = {1'b1, text_q};
                  shown_wr    = '{en: 1'b1, addr: ref_ff, data: text_q};
               end else begin
                  res_wr_data = {1'b0, cmd_ref};
               end
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer, architectural state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         defer_ff   <= 1'b0;
         cursor_ff  <= '0;
         disp_ff    <= '0;
         ref_ff     <= '0;
         retdef_ff  <= 1'b0;
         res_cnt_ff <= '0;
         pending_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            defer_ff <= csr_wr_data;
         end
         if (res_wr_en) begin
            res_cnt_ff <= res_cnt_ff + RES_CNT_W'(1);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  res_cnt_ff <= '0;
                  pending_ff <= 1'b0;
                  busy_ff    <= req_chan.lcd_busy;
                  mod_ff     <= req_chan.column;
                  row_bit_ff <= (ROWS > 1) ? req_chan.row_index[0] : 1'b0;
                  unique case (mode_type'(req_chan.mode))
                     MODE_WRITE: begin
                        if (req_chan.char_code == CR_CHAR) begin
                           retdef_ff <= 1'b1;
                           state_ff  <= S_FINISH;
                        end else if (req_chan.char_code == LF_CHAR) begin
                           retdef_ff <= 1'b0;
                           put_ch_ff <= SPACE_CHAR;
                           fill_ff   <= 1'b1;
                           lf_ff     <= 1'b1;
                           state_ff  <= S_FILL;
                        end else begin
                           retdef_ff <= 1'b0;
                           cursor_ff <= wc_cursor;
                           put_ch_ff <= req_chan.char_code;
                           fill_ff   <= 1'b0;
                           state_ff  <= S_PUT_RD;
                        end
                     end
                     MODE_CURSOR: begin
                        state_ff <= S_MOD;
                     end
                     MODE_CLEAR: begin
                        if (defer_ff) begin
                           scan_ff  <= '0;
                           state_ff <= S_DCLR;
                        end else begin
                           cursor_ff <= '0;
                           put_ch_ff <= SPACE_CHAR;
                           fill_ff   <= 1'b1;
                           lf_ff     <= 1'b0;
                           state_ff  <= S_FILL;
                        end
                     end
                     MODE_REFRESH: begin
                        cnt_ff   <= '0;
                        state_ff <= defer_ff ? S_REF_RD : S_FINISH;
                     end
                     default: state_ff <= S_FINISH;
                  endcase
               end
            end
            // reduce the column by repeated subtraction
            S_MOD: begin
               if (mod_ff >= COLS8) begin
                  mod_ff <= mod_ff - COLS8;
               end else begin
                  cursor_ff <= {2'b0, mod_ff[5:0]} | (row_bit_ff ? STRIDE8 : 8'd0);
                  state_ff  <= S_FINISH;
               end
            end
            // pad the current row, then move on
            S_FILL: begin
               if ({2'b0, cursor_ff[5:0]} < COLS8) begin
                  state_ff <= S_PUT_RD;
               end else if (lf_ff) begin
                  cursor_ff <= next_row(cursor_ff);
                  state_ff  <= S_FINISH;
               end else if (int'(cursor_ff[7:6]) < ROWS_LAST) begin
                  cursor_ff <= next_row(cursor_ff);
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_PUT_RD: begin
               state_ff <= S_PUT_CMP;
            end
            S_PUT_CMP: begin
               if (!defer_ff && put_diff && need_addr && room2) begin
                  disp_ff  <= cursor_ff;
                  state_ff <= S_PUT_DATA;
               end else if (!defer_ff && put_diff && !need_addr && room1) begin
                  state_ff <= S_PUT_DATA;
               end else begin
                  cursor_ff <= cursor_ff + 8'd1;
                  state_ff  <= fill_ff ? S_FILL : S_FINISH;
               end
            end
            S_PUT_DATA: begin
               disp_ff   <= cursor_ff + 8'd1;
               cursor_ff <= cursor_ff + 8'd1;
               state_ff  <= fill_ff ? S_FILL : S_FINISH;
            end
            // blank the text store one cell per cycle
            S_DCLR: begin
               if ({2'b0, scan_ff[5:0]} == COLS8 - 8'd1) begin
                  if (int'(scan_ff[6]) < ROWS_LAST) begin
                     scan_ff <= STORE_AW'(ROW_STRIDE);
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end else begin
                  scan_ff <= scan_ff + STORE_AW'(1);
               end
            end
            S_REF_RD: begin
               state_ff <= S_REF_CMP;
            end
            // compare one cell per pass; stop at the first difference
            S_REF_CMP: begin
               if (ref_diff) begin
                  pending_ff <= 1'b1;
                  state_ff   <= S_FINISH;
                  if (!busy_ff) begin
                     if (ref_hit) begin
                        disp_ff <= disp_ff + 8'd1;
                        ref_ff  <= adv_ref(ref_ff);
                     end else begin
                        disp_ff <= {1'b0, ref_ff};
                     end
                  end
               end else if (cnt_ff == CNT_W'(CELLS - 1)) begin
                  ref_ff   <= '0;
                  state_ff <= S_FINISH;
               end else begin
                  ref_ff   <= adv_ref(ref_ff);
                  cnt_ff   <= cnt_ff + CNT_W'(1);
                  state_ff <= S_REF_RD;
               end
            end
            S_FINISH: begin
               rd_idx_ff <= '0;
               if (res_cnt_ff == '0) begin
                  out_op_ff   <= 1'b0;
                  out_data_ff <= 1'b0;
                  out_byte_ff <= '0;
                  out_last_ff <= 1'b1;
                  out_vld_ff  <= 1'b1;
                  state_ff    <= S_WAIT_OUT;
               end else begin
                  state_ff <= S_DRAIN_RD;
               end
            end
            S_DRAIN_RD: begin
               state_ff <= S_DRAIN_LD;
            end
            S_DRAIN_LD: begin
               out_op_ff   <= 1'b1;
               out_data_ff <= res_q[8];
               out_byte_ff <= res_q[7:0];
               out_last_ff <= {1'b0, rd_idx_ff} == res_cnt_ff - RES_CNT_W'(1);
               out_vld_ff  <= 1'b1;
               state_ff    <= S_WAIT_OUT;
            end
            // hold the beat until taken
            S_WAIT_OUT: begin
               if (rsp_chan.ready) begin
                  out_vld_ff <= 1'b0;
                  rd_idx_ff  <= rd_idx_ff + RES_AW'(1);
                  state_ff   <= out_last_ff ? S_IDLE : S_DRAIN_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready           = state_ff == S_IDLE;
   assign rsp_chan.valid           = out_vld_ff;
   assign rsp_chan.op_valid        = out_op_ff;
   assign rsp_chan.is_data         = out_data_ff;
   assign rsp_chan.lcd_byte        = out_byte_ff;
   assign rsp_chan.refresh_pending = pending_ff;
   assign rsp_chan.cursor_position = cursor_ff;
   assign rsp_chan.last            = out_last_ff;

   `CLSB_NEVER(a_no_overlap, clock, reset, req_chan.ready && rsp_chan.valid, "accept during drain")
   `CLSB_ASSERT(a_res_bound, clock, reset, res_cnt_ff <= RES_CNT_W'(MAX_RESULTS), "result overflow")
   `CLSB_NEVER(a_imm_pending, clock, reset, rsp_chan.valid && !defer_ff && rsp_chan.refresh_pending, "pending in immediate mode")
   `CLSB_NEVER(a_cursor_range, clock, reset, cursor_ff[7], "cursor out of store")

endmodule

// ===== verif/char_lcd_shadow_buffer_refresh_unit_tb.sv =====
`timescale 1ns / 1ps
module char_lcd_shadow_buffer_refresh_unit_tb import clsb_pkg::*;;

   localparam int NCOLS = COLS_DEF;
   localparam int NROWS = ROWS_DEF;
   localparam int SPAN  = NROWS * ROW_STRIDE;

   typedef struct {
      mode_type   mode;
      logic [7:0] char_code;
      logic [7:0] column;
      logic [7:0] row_index;
      logic       lcd_busy;
   } lcd_cmd_type;

   typedef struct {
      logic       op_valid;
      logic       is_data;
      logic [7:0] lcd_byte;
      logic       refresh_pending;
      logic [7:0] cursor_position;
      logic       last;
   } lcd_beat_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   clsb_req_if req_chan ();
   clsb_rsp_if rsp_chan ();

   char_lcd_shadow_buffer_refresh_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan.sink),
      .rsp_chan   (rsp_chan.source),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Shadow of the block's state
   logic [7:0] text_cells [STORE_DEPTH];
   logic [7:0] shown_cells [STORE_DEPTH];
   logic [7:0] cursor_addr;
   logic [7:0] disp_addr;
   logic [7:0] scan_addr;
   logic       cr_held;
   logic       deferred_mode;

   lcd_cmd_type  pending_cmds [$];
   lcd_beat_type expected_beats [$];
   lcd_beat_type op_beats [$];

   int  err_count;
   int  cmds_sent;
   int  beats_seen;
   int  ops_seen;
   bit  idling_on;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at beat %0d: %s got 0x%0h expected 0x%0h",
               beats_seen, what, got, want);
      err_count++;
   endtask

   function automatic void add_op(input logic d, input logic [7:0] b);
      lcd_beat_type e;
      if (op_beats.size() < MAX_RESULTS) begin
         e.op_valid = 1'b1;
         e.is_data = d;
         e.lcd_byte = b;
         e.refresh_pending = 1'b0;
         e.cursor_position = '0;
         e.last = 1'b0;
         op_beats.push_back(e);
      end
   endfunction

   function automatic logic [7:0] row_after(input int a);
      return 8'((a + ROW_STRIDE - a % ROW_STRIDE) % SPAN);
   endfunction

   function automatic void put_cell(input logic [7:0] ch);
      logic [6:0] idx;
      bit need_addr;
      int need;
      idx = cursor_addr[6:0];
      text_cells[idx] = ch;
      if (!deferred_mode && text_cells[idx] != shown_cells[idx]) begin
         need_addr = disp_addr != cursor_addr;
         need = need_addr ? 2 : 1;
         if (op_beats.size() + need <= MAX_RESULTS) begin
            if (need_addr) begin
               add_op(1'b0, SET_ADDR_CMD | 8'(cursor_addr % SPAN));
               disp_addr = cursor_addr;
            end
            add_op(1'b1, ch);
            shown_cells[idx] = ch;
            disp_addr = disp_addr + 8'd1;
         end
      end
      cursor_addr = cursor_addr + 8'd1;
   endfunction

   function automatic void step_scan();
      int a;
      a = (int'(scan_addr) + 1) % STORE_DEPTH;
      if (a % ROW_STRIDE >= NCOLS) a = row_after(a);
      scan_addr = 8'(a % STORE_DEPTH);
   endfunction

   function automatic bit refresh_one(input logic busy);
      logic [6:0] idx;
      if (!deferred_mode) return 1'b0;
      for (int i = 0; i < NROWS * NCOLS; i++) begin
         idx = scan_addr[6:0];
         if (text_cells[idx] != shown_cells[idx]) begin
            if (busy) return 1'b1;
            if (disp_addr == scan_addr) begin
               add_op(1'b1, text_cells[idx]);
               shown_cells[idx] = text_cells[idx];
               disp_addr = disp_addr + 8'd1;
               step_scan();
            end else begin
               add_op(1'b0, SET_ADDR_CMD | scan_addr);
               disp_addr = scan_addr;
            end
            return 1'b1;
         end
         step_scan();
      end
      scan_addr = '0;
      return 1'b0;
   endfunction

   // Work out every beat one command produces
   function automatic void predict_beats(input lcd_cmd_type c);
      bit pend;
      int line_end;
      lcd_beat_type e;
      pend = 1'b0;
      op_beats.delete();
      case (c.mode)
         MODE_WRITE: begin
            if (c.char_code == CR_CHAR) begin
               cr_held = 1'b1;
            end else if (c.char_code == LF_CHAR) begin
               cr_held = 1'b0;
               line_end = int'(cursor_addr - cursor_addr % ROW_STRIDE) + NCOLS;
               while (int'(cursor_addr) < line_end) put_cell(SPACE_CHAR);
               cursor_addr = row_after(cursor_addr);
            end else begin
               if (cr_held) begin
                  cursor_addr = 8'(cursor_addr - cursor_addr % ROW_STRIDE);
                  cr_held = 1'b0;
               end
               if (cursor_addr % ROW_STRIDE >= NCOLS) cursor_addr = row_after(cursor_addr);
               put_cell(c.char_code);
            end
         end
         MODE_CURSOR: begin
            cursor_addr = 8'((c.column % NCOLS) + (c.row_index % NROWS) * ROW_STRIDE);
         end
         MODE_CLEAR: begin
            for (int r = 0; r < NROWS; r++) begin
               if (deferred_mode) begin
                  for (int k = 0; k < NCOLS; k++)
                     text_cells[(k + r * ROW_STRIDE) % STORE_DEPTH] = SPACE_CHAR;
               end else begin
                  cursor_addr = 8'(r * ROW_STRIDE);
                  for (int k = 0; k < NCOLS; k++) put_cell(SPACE_CHAR);
               end
            end
         end
         default: begin
            pend = refresh_one(c.lcd_busy);
         end
      endcase
      if (op_beats.size() == 0) begin
         e.op_valid = 1'b0;
         e.is_data = 1'b0;
         e.lcd_byte = '0;
         op_beats.push_back(e);
      end
      foreach (op_beats[k]) begin
         e = op_beats[k];
         e.refresh_pending = pend;
         e.cursor_position = cursor_addr;
         e.last = (k == op_beats.size() - 1);
         expected_beats.push_back(e);
      end
   endfunction

   // Drive command beats from the pending queue, with random gaps while idling is on
   int src_gap;
   always @(posedge clock) begin
      lcd_cmd_type c;
      if (reset) begin
         req_chan.valid <= 1'b0;
         src_gap = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (src_gap > 0) begin
            src_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.mode <= c.mode;
            req_chan.char_code <= c.char_code;
            req_chan.column <= c.column;
            req_chan.row_index <= c.row_index;
            req_chan.lcd_busy <= c.lcd_busy;
            predict_beats(c);
            cmds_sent++;
            if (idling_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 18);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Check each result beat against the oldest expected one
   int sink_gap;
   always @(posedge clock) begin
      lcd_beat_type e;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         sink_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               e = expected_beats.pop_front();
               if (rsp_chan.op_valid !== e.op_valid)
                  report_mismatch("op_valid", rsp_chan.op_valid, e.op_valid);
               if (rsp_chan.is_data !== e.is_data)
                  report_mismatch("is_data", rsp_chan.is_data, e.is_data);
               if (rsp_chan.lcd_byte !== e.lcd_byte)
                  report_mismatch("lcd_byte", rsp_chan.lcd_byte, e.lcd_byte);
               if (rsp_chan.refresh_pending !== e.refresh_pending)
                  report_mismatch("refresh_pending", rsp_chan.refresh_pending,
                                  e.refresh_pending);
               if (rsp_chan.cursor_position !== e.cursor_position)
                  report_mismatch("cursor_position", rsp_chan.cursor_position,
                                  e.cursor_position);
               if (rsp_chan.last !== e.last)
                  report_mismatch("last", rsp_chan.last, e.last);
               if (e.op_valid) ops_seen++;
            end
            beats_seen++;
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_chan.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(1, 18) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic lcd_cmd_type mk_cmd(input mode_type m, input int ch, input int col = 0,
                                          input int row = 0, input int busy = 0);
      lcd_cmd_type c;
      c.mode = m;
      c.char_code = 8'(ch);
      c.column = 8'(col);
      c.row_index = 8'(row);
      c.lcd_busy = busy[0];
      return c;
   endfunction

   function automatic lcd_cmd_type rand_cmd(input bit refresh_heavy);
      int pick;
      int ch;
      pick = $urandom_range(0, 99);
      ch = $urandom_range(0, 255);
      if ($urandom_range(0, 9) == 0) ch = CR_CHAR;
      else if ($urandom_range(0, 9) == 0) ch = LF_CHAR;
      if (refresh_heavy && pick < 60)
         return mk_cmd(MODE_REFRESH, ch, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 4) == 0);
      if (pick < 70)
         return mk_cmd(MODE_WRITE, ch, $urandom_range(0, 255), $urandom_range(0, 255));
      if (pick < 85)
         return mk_cmd(MODE_CURSOR, ch, $urandom_range(0, 255), $urandom_range(0, 255));
      if (pick < 90)
         return mk_cmd(MODE_CLEAR, ch, $urandom_range(0, 255), $urandom_range(0, 255));
      return mk_cmd(MODE_REFRESH, ch, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 1));
   endfunction

   // Wait for a quiet block, then write defer_updates
   task automatic set_defer(input logic v);
      wait (pending_cmds.size() == 0 && !req_chan.valid && expected_beats.size() == 0);
      repeat (150) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      deferred_mode = v;
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_WRITE;
      req_chan.char_code = '0;
      req_chan.column = '0;
      req_chan.row_index = '0;
      req_chan.lcd_busy = 1'b0;
      rsp_chan.ready = 1'b0;
      foreach (text_cells[i]) begin
         text_cells[i] = SPACE_CHAR;
         shown_cells[i] = SPACE_CHAR;
      end
      cursor_addr = '0;
      disp_addr = '0;
      scan_addr = '0;
      cr_held = 1'b0;
      deferred_mode = 1'b0;
      err_count = 0;
      cmds_sent = 0;
      beats_seen = 0;
      ops_seen = 0;
      idling_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: immediate mode
      set_defer(1'b0);
      pending_cmds.push_back(mk_cmd(MODE_WRITE, 8'h41));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, CR_CHAR));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, 8'h42));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, LF_CHAR));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, 8'hFF));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, 8'h00));
      pending_cmds.push_back(mk_cmd(MODE_CURSOR, 8'hFF, 255, 255, 1));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, 8'h5A));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, 8'h5B));
      pending_cmds.push_back(mk_cmd(MODE_REFRESH, 0, 0, 0, 1));
      pending_cmds.push_back(mk_cmd(MODE_CLEAR, 0));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, LF_CHAR));

      // Directed: deferred mode with busy, in-step and clear cases
      set_defer(1'b1);
      pending_cmds.push_back(mk_cmd(MODE_CURSOR, 0, 14, 0));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, 8'h31));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, 8'h32));
      pending_cmds.push_back(mk_cmd(MODE_WRITE, 8'h33));
      pending_cmds.push_back(mk_cmd(MODE_REFRESH, 0, 0, 0, 1));
      for (int i = 0; i < 7; i++) pending_cmds.push_back(mk_cmd(MODE_REFRESH, 0));
      pending_cmds.push_back(mk_cmd(MODE_CLEAR, 0));
      pending_cmds.push_back(mk_cmd(MODE_REFRESH, 0));

      // Random phases, alternating the update mode; the last one runs without idling
      for (int ph = 0; ph < 7; ph++) begin
         set_defer(ph[0] ? 1'b0 : 1'b1);
         if (ph == 6) idling_on = 1'b0;
         for (int i = 0; i < 24; i++) pending_cmds.push_back(rand_cmd(1'b0));
         for (int i = 0; i < 14; i++) pending_cmds.push_back(rand_cmd(1'b1));
      end

      wait (pending_cmds.size() == 0 && !req_chan.valid && expected_beats.size() == 0);
      repeat (200) @(posedge clock);
      if (expected_beats.size() != 0)
         report_mismatch("beats left over", expected_beats.size(), 0);
      $display("sent %0d commands, checked %0d result beats (%0d display operations)",
               cmds_sent, beats_seen, ops_seen);
      $display("both update modes covered, with and without handshake idling");
      if (err_count == 0) begin
         $display("char_lcd_shadow_buffer_refresh_unit regression: pass");
      end else begin
         $display("char_lcd_shadow_buffer_refresh_unit regression: fail");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #20_000_000;
      $display("timeout with %0d beats outstanding", expected_beats.size());
      $display("char_lcd_shadow_buffer_refresh_unit regression: fail");
      $finish;
   end

endmodule
